@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Clock and reset are taken from the
// scope of the module that expands the macro (clk, rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// prop must never hold out of reset
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

@@ src/ifr_pkg.sv @@
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared widths, status codes and constants of the fourth-root checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ifr_pkg;

  localparam int VALUE_WIDTH = 128;
  localparam int WORD_W      = 64;
  localparam int GUESS_W     = 31;
  localparam int ROOT_W      = 31;
  localparam int STATUS_W    = 2;
  localparam int ITER_W      = 8;
  localparam int X_W         = 32;
  localparam int WIDE_W      = 2 * WORD_W;

  localparam logic [WIDE_W-1:0] VALUE_MASK = {WIDE_W{1'b1}} >> (WIDE_W - VALUE_WIDTH);
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST = ITER_W'(100);

  localparam logic [STATUS_W-1:0] ST_EXACT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_POWER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CONV   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

endpackage

`default_nettype wire

@@ src/ifr_in_if.sv @@
// ----------------------------------------------------------------------------
// ifr_in_if
// Input channel: 128-bit value as two words plus the starting estimate.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifr_in_if import ifr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  value_high;
  logic [WORD_W-1:0]  value_low;
  logic [GUESS_W-1:0] guess;

  modport source (output valid, output value_high, output value_low, output guess,
                  input ready);
  modport sink   (input valid, input value_high, input value_low, input guess,
                  output ready);
endinterface

`default_nettype wire

@@ src/ifr_out_if.sv @@
// ----------------------------------------------------------------------------
// ifr_out_if
// Result channel: root and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifr_out_if import ifr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROOT_W-1:0]   root;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output root, output status, input ready);
  modport sink   (input valid, input root, input status, output ready);
endinterface

`default_nettype wire

@@ src/ifr_mul.sv @@
// ----------------------------------------------------------------------------
// ifr_mul
// Bit-serial shift-add multiplier: wide operand times 32-bit operand,
// one multiplier bit per cycle, stops early when the remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_mul import ifr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WIDE_W-1:0] a,
  input  wire logic [X_W-1:0]    b,
  output logic                   done,
  output logic [WIDE_W-1:0]      prod
);

  logic              busy_r;
  logic              done_r;
  logic [WIDE_W-1:0] acc_r;
  logic [WIDE_W-1:0] a_r;
  logic [X_W-1:0]    b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        a_r    <= a;
        b_r    <= b;
      end else if (busy_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) acc_r <= acc_r + a_r;
          a_r <= {a_r[WIDE_W-2:0], 1'b0};
          b_r <= {1'b0, b_r[X_W-1:1]};
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

@@ src/ifr_div.sv @@
// ----------------------------------------------------------------------------
// ifr_div
// Restoring divider, one quotient bit per cycle over the 128-bit numerator.
// Only the low 32 quotient bits are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_div import ifr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WIDE_W-1:0] num,
  input  wire logic [WIDE_W-1:0] den,
  output logic                   done,
  output logic [X_W-1:0]         quo
);

  localparam int CNT_W = $clog2(WIDE_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WIDE_W-1:0] rem_r;
  logic [WIDE_W-1:0] num_r;
  logic [WIDE_W-1:0] den_r;
  logic [X_W-1:0]    quo_r;
  logic [WIDE_W-1:0] shifted;
  logic              fits;

  assign shifted = {rem_r[WIDE_W-2:0], num_r[WIDE_W-1]};
  assign fits    = (shifted >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? (shifted - den_r) : shifted;
        quo_r <= {quo_r[X_W-2:0], fits};
        num_r <= {num_r[WIDE_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

@@ src/integer_fourth_root_check.sv @@
// Sequencing: each Newton step runs three serial multiplies (x^2, x^3, x^4),
//   the difference and the divide; steps repeat up to iteration_limit, and the
//   root test then tries up to three candidates of three multiplies each.
// Throughput: one item at a time; the next beat is taken once the sequencer
//   is back in idle, while a finished result may still wait at the output.
// Reset: synchronous, active low; iteration_limit returns to 100.
// ----------------------------------------------------------------------------
// integer_fourth_root_check
// Newton search for an exact integer fourth root, built on a bit-serial
// multiplier and a bit-serial divider under one sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module integer_fourth_root_check import ifr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ITER_W-1:0] cfg_wdata,
  ifr_in_if.sink                 in_ch,
  ifr_out_if.source              out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_MUL_WAIT, S_DIFF, S_NUM, S_DIV_WAIT, S_ROOT_SEL, S_FINISH
  } state_t;

  localparam logic [1:0] CAND_SAME = 2'd0;
  localparam logic [1:0] CAND_UP   = 2'd1;
  localparam logic [1:0] CAND_DOWN = 2'd2;
  localparam logic [1:0] CAND_NONE = 2'd3;

  state_t              state_r;
  logic [ITER_W-1:0]   limit_r;
  logic [ITER_W-1:0]   it_r;
  logic [WIDE_W-1:0]   y_r;
  logic [X_W-1:0]      x_r;
  logic [X_W-1:0]      mag_r;
  logic [WIDE_W-1:0]   m3_r;
  logic [WIDE_W-1:0]   m4_r;
  logic [WIDE_W:0]     diff_r;
  logic [WIDE_W-1:0]   num_r;
  logic [1:0]          mul_n_r;
  logic                root_mode_r;
  logic [1:0]          cand_r;
  logic [ROOT_W-1:0]   res_root_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                out_valid_r;
  logic [ROOT_W-1:0]   out_root_r;
  logic [STATUS_W-1:0] out_status_r;

  logic              mul_start_r;
  logic [WIDE_W-1:0] mul_a_r;
  logic              mul_done;
  logic [WIDE_W-1:0] mul_prod;
  logic              div_start_r;
  logic              div_done;
  logic [X_W-1:0]    div_quo;

  logic [X_W-1:0] x_mag;
  logic [X_W-1:0] q_signed;
  logic [X_W-1:0] x_nxt;
  logic [X_W-1:0] cand_off;
  logic [X_W-1:0] cand;

  assign x_mag    = x_r[X_W-1] ? (~x_r + 1'b1) : x_r;
  assign q_signed = (diff_r[WIDE_W] ^ x_r[X_W-1]) ? (~div_quo + 1'b1) : div_quo;
  assign x_nxt    = x_r + q_signed;

  always_comb begin
    case (cand_r)
      CAND_UP:   cand_off = X_W'(1);
      CAND_DOWN: cand_off = {X_W{1'b1}};
      default:   cand_off = '0;
    endcase
  end
  assign cand = x_r + cand_off;

  ifr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mag_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ifr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_r),
    .den   ({m3_r[WIDE_W-3:0], 2'b00}),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= ITER_LIMIT_RST;
      out_valid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_we) limit_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            y_r  <= {in_ch.value_high, in_ch.value_low} & VALUE_MASK;
            x_r  <= {1'b0, in_ch.guess};
            it_r <= '0;
            if (in_ch.guess == '0) begin
              res_root_r   <= '0;
              res_status_r <= ST_ZERO;
              state_r      <= S_FINISH;
            end else begin
              state_r <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (it_r == limit_r) begin
            res_root_r   <= '0;
            res_status_r <= ST_NO_CONV;
            state_r      <= S_FINISH;
          end else if (x_r == '0) begin
            res_root_r   <= '0;
            res_status_r <= ST_ZERO;
            state_r      <= S_FINISH;
          end else begin
            mag_r       <= x_mag;
            mul_a_r     <= WIDE_W'(x_mag);
            mul_start_r <= 1'b1;
            mul_n_r     <= 2'd0;
            root_mode_r <= 1'b0;
            state_r     <= S_MUL_WAIT;
          end
        end
        S_MUL_WAIT: begin
          // chain of three multiplies by mag: m^2, m^3, m^4
          if (mul_done) begin
            if (mul_n_r != 2'd2) begin
              if (mul_n_r == 2'd1) m3_r <= mul_prod;
              mul_a_r     <= mul_prod;
              mul_start_r <= 1'b1;
              mul_n_r     <= mul_n_r + 1'b1;
            end else if (root_mode_r) begin
              if (mul_prod == y_r) begin
                res_root_r   <= cand[ROOT_W-1:0];
                res_status_r <= ST_EXACT;
                state_r      <= S_FINISH;
              end else begin
                cand_r  <= cand_r + 1'b1;
                state_r <= S_ROOT_SEL;
              end
            end else begin
              m4_r    <= mul_prod;
              state_r <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          // top bit set means y < x^4; the step sign is this bit XOR the sign of x
          diff_r  <= {1'b0, y_r} - {1'b0, m4_r};
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r       <= diff_r[WIDE_W] ? (~diff_r[WIDE_W-1:0] + 1'b1)
                                        : diff_r[WIDE_W-1:0];
          div_start_r <= 1'b1;
          state_r     <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (x_nxt == x_r) begin
              cand_r  <= CAND_SAME;
              state_r <= S_ROOT_SEL;
            end else begin
              x_r     <= x_nxt;
              it_r    <= it_r + 1'b1;
              state_r <= S_STEP;
            end
          end
        end
        S_ROOT_SEL: begin
          if (cand_r == CAND_NONE) begin
            res_root_r   <= '0;
            res_status_r <= ST_NOT_POWER;
            state_r      <= S_FINISH;
          end else if (cand[X_W-1]) begin
            cand_r <= cand_r + 1'b1;   // negative candidate never matches
          end else begin
            mag_r       <= cand;
            mul_a_r     <= WIDE_W'(cand);
            mul_start_r <= 1'b1;
            mul_n_r     <= 2'd0;
            root_mode_r <= 1'b1;
            state_r     <= S_MUL_WAIT;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_root_r   <= res_root_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.root   = out_root_r;
  assign out_ch.status = out_status_r;

  `ASSERT_ALWAYS(a_root_zero_on_fail,
    (out_valid_r && out_status_r != ST_EXACT) |-> (out_root_r == '0),
    "nonzero root with failing status")
  `ASSERT_ALWAYS(a_mul_done_expected, mul_done |-> (state_r == S_MUL_WAIT),
    "multiplier finished outside its wait state")
  `ASSERT_ALWAYS(a_div_done_expected, div_done |-> (state_r == S_DIV_WAIT),
    "divider finished outside its wait state")
  `ASSERT_NEVER(a_no_double_start, mul_start_r && div_start_r,
    "multiplier and divider started together")

endmodule

`default_nettype wire
